@@ rtl/pva_pkg.sv @@
// Shared types and constants for the polyphonic voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

	localparam int VOICES_DEF    = 32;
	localparam int MAX_BLOCK_DEF = 4096;

	localparam int CMD_W    = 2;
	localparam int NOTE_W   = 7;
	localparam int OFFSET_W = 12;
	localparam int BPOS_W   = 47;
	localparam int SLOT_W   = 5;
	localparam int TIME_W   = 48;
	localparam int MASK_W   = 32;
	localparam int COUNT_W  = 6;
	localparam int SAT_W    = 17;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_NOTE_ON     = 2'd0,
		CMD_NOTE_OFF    = 2'd1,
		CMD_BLOCK_START = 2'd2,
		CMD_VOICE_END   = 2'd3
	} cmd_e_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ALLOC,
		OP_NOTE_OFF,
		OP_BLOCK,
		OP_FREE
	} op_kind_t;

	// broadcast to every cell
	typedef struct packed {
		op_kind_t            kind;
		logic [NOTE_W-1:0]   note;
		logic [SLOT_W-1:0]   slot;
		logic [TIME_W-1:0]   start;
	} op_t;

	// running record handed cell to cell during an allocation scan
	typedef struct packed {
		logic                found_free;
		logic                have;
		logic [TIME_W-1:0]   oldest;
		logic [SLOT_W-1:0]   pick;
	} scan_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ALLOC,
		ST_EXEC
	} state_t;

endpackage

@@ rtl/poly_voice_allocator.sv @@
// Top level of the polyphonic voice allocator: cell chain plus sequencer.
`timescale 1ns / 1ps
//
// Voice slot allocator with oldest-voice stealing.
// Input stream (s_*): one request per event. s_tuser carries the command
// (note on, note off, block start, voice ended); s_tdata carries note,
// sample offset, block position and voice index.
// Output stream (m_*): exactly one result per request: assigned slot,
// stolen flag, note-off release mask, active voice count, drained flag.
// Throughput: one request at a time. A note on is accepted, then the
// allocation record walks the chain of slot cells one cell per clock,
// each cell doing one 48-bit age compare, before the pick is written.
// All other commands go straight to execution, since every cell acts on
// the broadcast operation in parallel.
// The result sits in an output register, so the next request is taken
// while a result waits; a stalled m_tready holds the result and blocks
// only the step that would write the next one.
// Reset (arst_n low) empties every slot, clears the drained flag and the
// voice count, and drops m_tvalid. No clearing pass is needed.
//
module poly_voice_allocator #(
	parameter int VOICES    = pva_pkg::VOICES_DEF,
	parameter int MAX_BLOCK = pva_pkg::MAX_BLOCK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [6:0] midi_note, [18:7] sample_offset, [65:19] block_position,
	// [70:66] voice_index, [71] zero
	input  logic [pva_pkg::IN_DATA_W-1:0]     s_tdata,
	// [1:0] cmd
	input  logic [pva_pkg::CMD_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [4:0] slot, [5] stolen, [37:6] release_mask, [43:38] active_count,
	// [44] drained, [47:45] zero
	output logic [pva_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import pva_pkg::*;

	op_t                op;
	scan_t              chain [VOICES+1];
	logic [VOICES-1:0]  hits;
	logic [VOICES-1:0]  freed_v;

	logic [SLOT_W-1:0]  out_slot;
	logic               out_stolen;
	logic [MASK_W-1:0]  out_mask;
	logic [COUNT_W-1:0] out_count;
	logic               out_drained;

	// empty record enters the head of the chain every cycle
	assign chain[0] = '{found_free: 1'b0, have: 1'b0, oldest: '0, pick: '0};

	for (genvar g = 0; g < VOICES; g++) begin : g_cell
		pva_cell #(
			.IDX (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.scan_in  (chain[g]),
			.scan_out (chain[g+1]),
			.hit      (hits[g]),
			.freed    (freed_v[g])
		);
	end

	pva_ctrl #(
		.VOICES    (VOICES),
		.MAX_BLOCK (MAX_BLOCK)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_cmd      (cmd_e_t'(s_tuser)),
		.in_note     (s_tdata[6:0]),
		.in_offset   (s_tdata[18:7]),
		.in_bpos     (s_tdata[65:19]),
		.in_vidx     (s_tdata[70:66]),
		.op          (op),
		.scan_res    (chain[VOICES]),
		.hits        (hits),
		.freed       (|freed_v),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_slot    (out_slot),
		.out_stolen  (out_stolen),
		.out_mask    (out_mask),
		.out_count   (out_count),
		.out_drained (out_drained)
	);

	assign m_tdata = {3'b000, out_drained, out_count, out_mask, out_stolen, out_slot};

endmodule

@@ rtl/pva_cell.sv @@
// One voice slot: slot state plus one step of the allocation scan.
`timescale 1ns / 1ps

module pva_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pva_pkg::op_t   op,
	input  pva_pkg::scan_t scan_in,
	output pva_pkg::scan_t scan_out,
	output logic           hit,
	output logic           freed
);
	import pva_pkg::*;

	logic              busy_q;
	logic              pend_q;
	logic              done_q;
	logic [NOTE_W-1:0] note_q;
	logic [TIME_W-1:0] start_q;
	scan_t             scan_q;
	scan_t             scan_nxt;
	logic              sel;

	assign sel   = (op.slot == SLOT_W'(IDX));
	assign hit   = (op.kind == OP_NOTE_OFF) && busy_q && (note_q == op.note) && !done_q;
	assign freed = (op.kind == OP_FREE) && sel && busy_q;

	// first free slot wins; otherwise strictly older start time wins (lowest index on tie)
	always_comb begin
		scan_nxt = scan_in;
		if (!scan_in.found_free) begin
			if (!busy_q) begin
				scan_nxt.found_free = 1'b1;
				scan_nxt.pick       = SLOT_W'(IDX);
			end else if (!scan_in.have || (start_q < scan_in.oldest)) begin
				scan_nxt.have   = 1'b1;
				scan_nxt.oldest = start_q;
				scan_nxt.pick   = SLOT_W'(IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			case (op.kind)
				OP_ALLOC: begin
					if (sel) begin
						busy_q <= 1'b1;
						pend_q <= 1'b0;
						done_q <= 1'b0;
					end
				end
				OP_NOTE_OFF: begin
					if (hit)
						pend_q <= 1'b1;
				end
				OP_BLOCK: begin
					if (busy_q && pend_q) begin
						pend_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
				OP_FREE: begin
					if (freed) begin
						busy_q <= 1'b0;
						pend_q <= 1'b0;
						done_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_nxt;
		if ((op.kind == OP_ALLOC) && sel) begin
			note_q  <= op.note;
			start_q <= op.start;
		end
	end

	assign scan_out = scan_q;

endmodule

@@ rtl/pva_ctrl.sv @@
// Sequencer: request capture, scan timing, result register and voice count.
`timescale 1ns / 1ps

module pva_ctrl #(
	parameter int VOICES    = pva_pkg::VOICES_DEF,
	parameter int MAX_BLOCK = pva_pkg::MAX_BLOCK_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pva_pkg::cmd_e_t               in_cmd,
	input  logic [pva_pkg::NOTE_W-1:0]    in_note,
	input  logic [pva_pkg::OFFSET_W-1:0]  in_offset,
	input  logic [pva_pkg::BPOS_W-1:0]    in_bpos,
	input  logic [pva_pkg::SLOT_W-1:0]    in_vidx,
	output pva_pkg::op_t                  op,
	input  pva_pkg::scan_t                scan_res,
	input  logic [VOICES-1:0]             hits,
	input  logic                          freed,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pva_pkg::SLOT_W-1:0]    out_slot,
	output logic                          out_stolen,
	output logic [pva_pkg::MASK_W-1:0]    out_mask,
	output logic [pva_pkg::COUNT_W-1:0]   out_count,
	output logic                          out_drained
);
	import pva_pkg::*;

	localparam int CNT_W = $clog2(VOICES + 1);
	localparam logic [SAT_W-1:0]   MB      = SAT_W'(MAX_BLOCK);
	localparam logic [SAT_W-1:0]   MB_M1   = SAT_W'(MAX_BLOCK - 1);
	localparam logic [COUNT_W-1:0] FULL    = COUNT_W'(VOICES);
	localparam logic [CNT_W-1:0]   SCAN_LAST = CNT_W'(VOICES - 1);

	state_t             state_q, state_nxt;
	cmd_e_t             cmd_q;
	logic [NOTE_W-1:0]  note_q;
	logic [SLOT_W-1:0]  vidx_q;
	logic [TIME_W-1:0]  start_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               m_valid_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               stolen_q;
	logic [MASK_W-1:0]  mask_q;
	logic [COUNT_W-1:0] count_q;
	logic               drained_q;

	logic               out_ok;
	logic               load;
	logic [SAT_W-1:0]   off_ext;
	logic [SAT_W-1:0]   off_sat;
	logic [MASK_W-1:0]  hits_ext;

	assign out_ok   = !m_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign off_ext  = SAT_W'(in_offset);
	assign off_sat  = (off_ext >= MB) ? MB_M1 : off_ext;

	always_comb begin
		hits_ext = '0;
		hits_ext[VOICES-1:0] = hits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		load      = 1'b0;
		op.kind   = OP_NONE;
		op.note   = note_q;
		op.slot   = (state_q == ST_ALLOC) ? scan_res.pick : vidx_q;
		op.start  = start_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nxt = (in_cmd == CMD_NOTE_ON) ? ST_SCAN : ST_EXEC;
			end
			ST_SCAN: begin
				if (cnt_q == SCAN_LAST)
					state_nxt = ST_ALLOC;
			end
			ST_ALLOC: begin
				if (out_ok) begin
					op.kind   = OP_ALLOC;
					load      = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_EXEC: begin
				if (out_ok) begin
					load      = 1'b1;
					state_nxt = ST_IDLE;
					unique case (cmd_q)
						CMD_NOTE_OFF:    op.kind = OP_NOTE_OFF;
						CMD_BLOCK_START: op.kind = OP_BLOCK;
						CMD_VOICE_END: begin
							if ({1'b0, vidx_q} < COUNT_W'(VOICES))
								op.kind = OP_FREE;
						end
						CMD_NOTE_ON:     op.kind = OP_NONE;
						default:         op.kind = OP_NONE;
					endcase
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// request capture; start time is worked out at accept
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q   <= in_cmd;
			note_q  <= in_note;
			vidx_q  <= in_vidx;
			start_q <= TIME_W'(in_bpos) + TIME_W'(off_sat);
		end
		if (load) begin
			slot_q   <= (state_q == ST_ALLOC) ? scan_res.pick : '0;
			stolen_q <= (state_q == ST_ALLOC) && !scan_res.found_free;
			mask_q   <= (op.kind == OP_NOTE_OFF) ? hits_ext : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
			count_q   <= '0;
			drained_q <= 1'b0;
		end else begin
			if (state_q == ST_SCAN)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;

			if (load)
				m_valid_q <= 1'b1;
			else if (out_ready)
				m_valid_q <= 1'b0;

			if (load && (state_q == ST_ALLOC)) begin
				drained_q <= !scan_res.found_free;
				if (scan_res.found_free)
					count_q <= count_q + COUNT_W'(1);
			end else if (load) begin
				if ((op.kind == OP_BLOCK) && (count_q != FULL))
					drained_q <= 1'b0;
				if (freed)
					count_q <= count_q - COUNT_W'(1);
			end
		end
	end

	assign out_valid   = m_valid_q;
	assign out_slot    = slot_q;
	assign out_stolen  = stolen_q;
	assign out_mask    = mask_q;
	assign out_count   = count_q;
	assign out_drained = drained_q;

endmodule

@@ rtl/pva_checker.sv @@
// Port-level assertions for the voice allocator, bound to the top level.
`timescale 1ns / 1ps

module pva_assertions #(
	parameter int VOICES = pva_pkg::VOICES_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pva_pkg::OUT_DATA_W-1:0] m_tdata
);
	import pva_pkg::*;

	// one request in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another was in flight");

	// a steal only happens with every slot busy
	a_steal_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> (m_tdata[43:38] == COUNT_W'(VOICES)) && m_tdata[44])
		else $error("steal reported without full table or drained flag");

	// count and slot stay within the table
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[43:38] <= COUNT_W'(VOICES)) && (m_tdata[4:0] < 6'(VOICES)))
		else $error("slot or active count out of range");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind poly_voice_allocator pva_assertions #(.VOICES(VOICES)) u_pva_assertions (.*);
